// ===== rtl/utf8_to_utf16_transcoder_assert.svh =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder assertion macros
// Shared concurrent assertion forms for the transcoder checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// same-cycle implication
`define UT16_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ut16 assertion failed");

// next-cycle implication
`define UT16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ut16 assertion failed");

`endif

// ===== rtl/ut16_pkg.sv =====
// ----------------------------------------------------------------------------
// ut16_pkg
// Beat types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ut16_pkg;

	localparam logic [20:0] REPL_CP     = 21'h00FFFD;
	localparam logic [20:0] UNICODE_MAX = 21'h10FFFF;
	localparam logic [20:0] MAX_1BYTE   = 21'h00007F;
	localparam logic [20:0] MAX_2BYTE   = 21'h0007FF;
	localparam logic [20:0] MAX_3BYTE   = 21'h00FFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h010000;
	localparam logic [15:0] HI_SURR     = 16'hD800;
	localparam logic [15:0] LO_SURR     = 16'hDC00;
	localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
	localparam logic [5:0]  LO_SURR_TAG = 6'b110111;
	localparam logic [1:0]  CONT_TAG    = 2'b10;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        run_last;
		logic        stream_end;
		logic        replaced;
	} out_beat_t;

	// decoded codepoint queued between front and back
	typedef struct packed {
		logic [20:0] cp;
		logic        stream_end;
		logic        replaced;
	} cp_entry_t;

endpackage

`default_nettype wire

// ===== rtl/ut16_front.sv =====
// ----------------------------------------------------------------------------
// ut16_front
// Byte decoder: tracks sequence state and pushes finished codepoints.
// ----------------------------------------------------------------------------
`default_nettype none

module ut16_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ut16_pkg::in_beat_t   in_data,
	input  wire logic                 q_full,
	output logic                      q_push,
	output ut16_pkg::cp_entry_t       q_wdata
);

	logic [20:0] codepoint_acc_q, codepoint_acc_d;
	logic [1:0]  bytes_remaining_q, bytes_remaining_d;
	logic [2:0]  sequence_length_q, sequence_length_d;
	logic [1:0]  discard_count_q, discard_count_d;
	logic        emit;
	logic        in_fire;
	logic [7:0]  b;
	logic [20:0] acc_sh;
	logic [2:0]  cp_len;
	logic        cp_bad;

	function automatic logic [2:0] len_of(input logic [20:0] cp);
		logic [2:0] l;
		if (cp <= ut16_pkg::MAX_1BYTE)      l = 3'd1;
		else if (cp <= ut16_pkg::MAX_2BYTE) l = 3'd2;
		else if (cp <= ut16_pkg::MAX_3BYTE) l = 3'd3;
		else                                l = 3'd4;
		return l;
	endfunction

	assign in_ready = ~q_full;
	assign in_fire  = in_valid & in_ready;
	assign q_push   = in_fire & emit;
	assign b        = in_data.data_byte;
	assign acc_sh   = {codepoint_acc_q[14:0], b[5:0]};
	assign cp_len   = len_of(acc_sh);
	assign cp_bad   = (acc_sh == 21'h00FFFE) || (acc_sh == 21'h00FFFF) ||
	                  (acc_sh >= 21'h00D800 && acc_sh <= 21'h00DFFF) ||
	                  (acc_sh > ut16_pkg::UNICODE_MAX) || (cp_len != sequence_length_q);

	always_comb begin
		codepoint_acc_d    = codepoint_acc_q;
		bytes_remaining_d  = bytes_remaining_q;
		sequence_length_d  = sequence_length_q;
		discard_count_d    = discard_count_q;
		emit               = 1'b0;
		q_wdata.cp         = ut16_pkg::REPL_CP;
		q_wdata.replaced   = 1'b1;
		q_wdata.stream_end = in_data.end_of_input;
		if (discard_count_q != 2'd0) begin
			discard_count_d = discard_count_q - 2'd1;
		end else if (bytes_remaining_q != 2'd0) begin
			if (b[7:6] != ut16_pkg::CONT_TAG) begin
				bytes_remaining_d = 2'd0;
				emit              = 1'b1;
			end else begin
				codepoint_acc_d   = acc_sh;
				bytes_remaining_d = bytes_remaining_q - 2'd1;
				if (bytes_remaining_q == 2'd1) begin
					emit = 1'b1;
					if (!cp_bad) begin
						q_wdata.cp       = acc_sh;
						q_wdata.replaced = 1'b0;
					end
				end else if (in_data.end_of_input) begin
					emit = 1'b1;
				end
			end
		end else begin
			unique casez (b)
				8'b0???????: begin
					emit             = 1'b1;
					q_wdata.cp       = {14'd0, b[6:0]};
					q_wdata.replaced = 1'b0;
				end
				8'b110?????: begin
					codepoint_acc_d   = {16'd0, b[4:0]};
					sequence_length_d = 3'd2;
					bytes_remaining_d = 2'd1;
					emit              = in_data.end_of_input;
				end
				8'b1110????: begin
					codepoint_acc_d   = {17'd0, b[3:0]};
					sequence_length_d = 3'd3;
					bytes_remaining_d = 2'd2;
					emit              = in_data.end_of_input;
				end
				8'b11110???: begin
					codepoint_acc_d   = {18'd0, b[2:0]};
					sequence_length_d = 3'd4;
					bytes_remaining_d = 2'd3;
					emit              = in_data.end_of_input;
				end
				default: begin
					discard_count_d = 2'd3;
					emit            = 1'b1;
				end
			endcase
		end
		if (in_data.end_of_input) begin
			codepoint_acc_d   = '0;
			bytes_remaining_d = '0;
			sequence_length_d = '0;
			discard_count_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codepoint_acc_q   <= '0;
			bytes_remaining_q <= '0;
			sequence_length_q <= '0;
			discard_count_q   <= '0;
		end else if (in_fire) begin
			codepoint_acc_q   <= codepoint_acc_d;
			bytes_remaining_q <= bytes_remaining_d;
			sequence_length_q <= sequence_length_d;
			discard_count_q   <= discard_count_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ut16_fifo.sv =====
// ----------------------------------------------------------------------------
// ut16_fifo
// Small first-word-fall-through queue of decoded codepoints.
// ----------------------------------------------------------------------------
`default_nettype none

module ut16_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire ut16_pkg::cp_entry_t  wdata,
	output logic                      full,
	input  wire logic                 pop,
	output logic                      rvalid,
	output ut16_pkg::cp_entry_t       rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	ut16_pkg::cp_entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == FULL_CNT);
	assign rvalid  = (count_q != '0);
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & rvalid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ut16_back.sv =====
// ----------------------------------------------------------------------------
// ut16_back
// Encoder: turns queued codepoints into UTF-16 units behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ut16_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	input  wire ut16_pkg::cp_entry_t  q_rdata,
	output logic                      q_pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output ut16_pkg::out_beat_t       out_data
);

	logic                low_pend_q;
	logic                out_valid_q;
	ut16_pkg::out_beat_t out_data_q;
	logic                load;
	logic                is_pair;
	logic [20:0]         v;

	assign load      = ~out_valid_q | out_ready;
	assign is_pair   = (q_rdata.cp > ut16_pkg::REPL_CP);
	assign v         = q_rdata.cp - ut16_pkg::SUPP_BASE;
	assign q_pop     = load & q_valid & (low_pend_q | ~is_pair);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= q_valid;
			if (q_valid) begin
				low_pend_q <= ~low_pend_q & is_pair;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_valid) begin
			out_data_q.stream_end <= q_rdata.stream_end;
			out_data_q.replaced   <= q_rdata.replaced;
			if (low_pend_q) begin
				out_data_q.code_unit <= ut16_pkg::LO_SURR | {6'd0, v[9:0]};
				out_data_q.run_last  <= 1'b1;
			end else if (is_pair) begin
				out_data_q.code_unit <= ut16_pkg::HI_SURR | {6'd0, v[19:10]};
				out_data_q.run_last  <= 1'b0;
			end else begin
				out_data_q.code_unit <= q_rdata.cp[15:0];
				out_data_q.run_last  <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// Path: a decoded codepoint is written into the queue, then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full; a surrogate pair holds the output
// for both its units, during which the codepoint queue absorbs further input.
// Bytes that give no unit (continuations, dropped bytes) take no queue slot.
// Reset: clears decode state, queue pointers and output valid; no clearing pass.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// UTF-8 byte stream in, UTF-16 code units out, invalid input mapped to U+FFFD.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ut16_pkg::in_beat_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output ut16_pkg::out_beat_t       out_data
);

	logic                q_full, q_push, q_pop, q_valid;
	ut16_pkg::cp_entry_t q_wdata, q_rdata;

	ut16_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	ut16_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rvalid (q_valid),
		.rdata  (q_rdata)
	);

	ut16_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== rtl/ut16_checker.sv =====
// ----------------------------------------------------------------------------
// ut16_checker
// Port-level checks on the transcoder output stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_utf16_transcoder_assert.svh"

module ut16_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire ut16_pkg::out_beat_t  out_data
);

	logic out_stall;
	logic out_take;
	logic unit_hi;
	logic unit_lo;
	logic unit_repl;

	assign out_stall = out_valid && !out_ready;
	assign out_take  = out_valid && out_ready;
	assign unit_hi   = (out_data.code_unit[15:10] == ut16_pkg::HI_SURR_TAG);
	assign unit_lo   = (out_data.code_unit[15:10] == ut16_pkg::LO_SURR_TAG);
	assign unit_repl = (out_data.code_unit == 16'hFFFD);

	`UT16_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(out_data))
	`UT16_ASSERT_IMPLY(a_repl_unit, clk, arst_n, out_valid && out_data.replaced, unit_repl)
	`UT16_ASSERT_IMPLY(a_hi_not_last, clk, arst_n, out_valid, out_data.run_last == !unit_hi)
	`UT16_ASSERT_NEXT(a_lo_follows, clk, arst_n, out_take && !out_data.run_last, out_valid && unit_lo)

endmodule

bind utf8_to_utf16_transcoder ut16_checker u_ut16_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ===== dv/utf8_to_utf16_transcoder_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_tb
// Drives UTF-8 bytes into the transcoder and checks every UTF-16 unit against
// a behavioural decoder kept in step with the accepted input. A short list of
// hand-picked bytes comes first, then random sequences: mostly well-formed
// characters of every length, with overlong, surrogate, out-of-range,
// truncated and noise sequences mixed in. Both sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		ut16_pkg::in_beat_t  beat;
		bit                  typed;
		ut16_pkg::out_beat_t unit;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	ut16_pkg::in_beat_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	ut16_pkg::out_beat_t out_data;

	utf8_to_utf16_transcoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// decoder state
	logic [20:0] acc;
	logic [1:0]  remaining;
	logic [2:0]  seq_len;
	logic [1:0]  drop_cnt;

	ut16_pkg::out_beat_t expected_units[$];
	ut16_pkg::in_beat_t  byte_plan[$];
	stim_row_t           stim_rows[$];
	int                  mismatches = 0;
	int                  live_items = 0;
	bit                  calm = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int utf8_len(logic [20:0] cp);
		if (cp <= ut16_pkg::MAX_1BYTE)
			return 1;
		if (cp <= ut16_pkg::MAX_2BYTE)
			return 2;
		if (cp <= ut16_pkg::MAX_3BYTE)
			return 3;
		return 4;
	endfunction

	task automatic emit_codepoint(input logic [20:0] cp, input logic rep, input logic eoi,
			input bit record);
		logic [19:0] v;
		if (!record)
			return;
		if (cp <= ut16_pkg::REPL_CP) begin
			expected_units.push_back('{cp[15:0], 1'b1, eoi, rep});
		end else begin
			v = 20'(cp - ut16_pkg::SUPP_BASE);
			expected_units.push_back('{ut16_pkg::HI_SURR | {6'b0, v[19:10]}, 1'b0, eoi, rep});
			expected_units.push_back('{ut16_pkg::LO_SURR | {6'b0, v[9:0]}, 1'b1, eoi, rep});
		end
	endtask

	task automatic transcode_byte(input ut16_pkg::in_beat_t b, input bit record);
		logic [7:0]  d;
		logic        eoi;
		logic [20:0] cp;
		bit          bad;
		int          len;
		d = b.data_byte;
		eoi = b.end_of_input;
		if (drop_cnt != 0) begin
			drop_cnt = drop_cnt - 2'd1;
		end else if (remaining != 0) begin
			if (d[7:6] != ut16_pkg::CONT_TAG) begin
				remaining = 2'd0;
				emit_codepoint(ut16_pkg::REPL_CP, 1'b1, eoi, record);
			end else begin
				acc = {acc[14:0], d[5:0]};
				remaining = remaining - 2'd1;
				if (remaining == 0) begin
					cp = acc;
					bad = (cp == 21'h00FFFE) || (cp == 21'h00FFFF) ||
						(cp >= 21'h00D800 && cp <= 21'h00DFFF) ||
						(cp > ut16_pkg::UNICODE_MAX) || (utf8_len(cp) != int'(seq_len));
					if (bad)
						emit_codepoint(ut16_pkg::REPL_CP, 1'b1, eoi, record);
					else
						emit_codepoint(cp, 1'b0, eoi, record);
				end else if (eoi) begin
					emit_codepoint(ut16_pkg::REPL_CP, 1'b1, eoi, record);
				end
			end
		end else begin
			casez (d)
				8'b0???????: len = 1;
				8'b110?????: len = 2;
				8'b1110????: len = 3;
				8'b11110???: len = 4;
				default:     len = 0;
			endcase
			if (len == 0) begin
				drop_cnt = 2'd3;
				emit_codepoint(ut16_pkg::REPL_CP, 1'b1, eoi, record);
			end else if (len == 1) begin
				emit_codepoint({14'b0, d[6:0]}, 1'b0, eoi, record);
			end else begin
				case (len)
					2:       acc = {16'b0, d[4:0]};
					3:       acc = {17'b0, d[3:0]};
					default: acc = {18'b0, d[2:0]};
				endcase
				seq_len = 3'(len);
				remaining = 2'(len - 1);
				if (eoi)
					emit_codepoint(ut16_pkg::REPL_CP, 1'b1, eoi, record);
			end
		end
		if (eoi) begin
			acc = '0;
			remaining = '0;
			seq_len = '0;
			drop_cnt = '0;
		end
	endtask

	task automatic send_byte(input ut16_pkg::in_beat_t b, input bit typed,
			input ut16_pkg::out_beat_t unit);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		live_items++;
		transcode_byte(b, !typed);
		if (typed)
			expected_units.push_back(unit);
	endtask

	task automatic drain_units();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_units.size() != 0)
			@(posedge clk);
	endtask

	function automatic void add_row(logic [7:0] d, logic eoi, bit typed, logic [15:0] cu,
			logic rep);
		stim_rows.push_back('{'{d, eoi}, typed, '{cu, 1'b1, eoi, rep}});
	endfunction

	function automatic void encode_utf8(logic [20:0] cp, int len, int keep);
		logic [7:0] seq[4];
		case (len)
			1: seq[0] = {1'b0, cp[6:0]};
			2: seq[0] = {3'b110, cp[10:6]};
			3: seq[0] = {4'b1110, cp[15:12]};
			default: seq[0] = {5'b11110, cp[20:18]};
		endcase
		for (int i = 1; i < len; i++)
			seq[i] = {ut16_pkg::CONT_TAG, 6'((cp >> (6 * (len - 1 - i))) & 21'h3F)};
		for (int i = 0; i < keep; i++)
			byte_plan.push_back('{seq[i], 1'b0});
	endfunction

	function automatic void plan_sequence();
		int          r;
		int          len;
		logic [20:0] cp;
		r = $urandom_range(0, 99);
		if (r < 22) begin
			encode_utf8(21'($urandom_range(0, 127)), 1, 1);
		end else if (r < 40) begin
			encode_utf8(21'($urandom_range(16'h80, 16'h7FF)), 2, 2);
		end else if (r < 56) begin
			case ($urandom_range(0, 7))
				0: cp = 21'h00D800 + 21'($urandom_range(0, 16'h7FF));
				1: cp = 21'h00FFFD + 21'($urandom_range(0, 2));
				2: cp = ($urandom_range(0, 1) != 0) ? 21'h000800 : 21'h00D7FF;
				default: cp = 21'($urandom_range(16'h800, 16'hFFFF));
			endcase
			encode_utf8(cp, 3, 3);
		end else if (r < 72) begin
			case ($urandom_range(0, 7))
				0: cp = ($urandom_range(0, 1) != 0) ? 21'h010000 : 21'h10FFFF;
				1: cp = 21'($urandom_range(32'h110000, 32'h1FFFFF));
				default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
			endcase
			encode_utf8(cp, 4, 4);
		end else if (r < 80) begin
			len = $urandom_range(2, 4);
			case (len)
				2: cp = 21'($urandom_range(0, 127));
				3: cp = 21'($urandom_range(0, 16'h7FF));
				default: cp = 21'($urandom_range(0, 16'hFFFF));
			endcase
			encode_utf8(cp, len, len);
		end else if (r < 89) begin
			len = $urandom_range(2, 4);
			encode_utf8(21'($urandom_range(16'h80, 16'h7FF)) << (5 * (len - 2)), len,
				$urandom_range(1, len - 1));
			if ($urandom_range(0, 1) != 0)
				byte_plan[$].end_of_input = 1'b1;
		end else begin
			repeat ($urandom_range(1, 4))
				byte_plan.push_back('{8'($urandom_range(0, 255)),
					1'($urandom_range(0, 9) == 0)});
		end
		if ($urandom_range(0, 11) == 0)
			byte_plan[$].end_of_input = 1'b1;
	endfunction

	// output side: random stalls, checked beat by beat
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if (!calm)
					stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		ut16_pkg::out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_units.size() == 0) begin
				$display("%0t: unexpected unit %h", $time, out_data);
				mismatches++;
			end else begin
				want = expected_units.pop_front();
				if (out_data.code_unit !== want.code_unit) begin
					$display("%0t: code_unit expected %h got %h", $time,
						want.code_unit, out_data.code_unit);
					mismatches++;
				end
				if (out_data.run_last !== want.run_last) begin
					$display("%0t: run_last expected %b got %b", $time,
						want.run_last, out_data.run_last);
					mismatches++;
				end
				if (out_data.stream_end !== want.stream_end) begin
					$display("%0t: stream_end expected %b got %b", $time,
						want.stream_end, out_data.stream_end);
					mismatches++;
				end
				if (out_data.replaced !== want.replaced) begin
					$display("%0t: replaced expected %b got %b", $time,
						want.replaced, out_data.replaced);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int next_drain;
		acc = '0;
		remaining = '0;
		seq_len = '0;
		drop_cnt = '0;

		add_row(8'h00, 1'b0, 1'b1, 16'h0000, 1'b0);
		add_row(8'h7F, 1'b0, 1'b1, 16'h007F, 1'b0);
		add_row(8'hFF, 1'b0, 1'b1, 16'hFFFD, 1'b1);	// bad lead, three dropped
		add_row(8'hC3, 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(8'h80, 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(8'h41, 1'b1, 1'b0, 16'h0000, 1'b0);	// end while dropping
		add_row(8'h80, 1'b1, 1'b1, 16'hFFFD, 1'b1);	// stray continuation
		add_row(8'hDF, 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(8'hC0, 1'b0, 1'b0, 16'h0000, 1'b0);	// overlong
		add_row(8'h80, 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(8'hED, 1'b0, 1'b0, 16'h0000, 1'b0);	// surrogate
		add_row(8'hA0, 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(8'h80, 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(8'hEF, 1'b0, 1'b0, 16'h0000, 1'b0);	// genuine U+FFFD
		add_row(8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(8'hBD, 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(8'hF4, 1'b0, 1'b0, 16'h0000, 1'b0);	// U+10FFFF pair
		add_row(8'h8F, 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(8'hE2, 1'b0, 1'b0, 16'h0000, 1'b0);	// broken by ASCII
		add_row(8'h41, 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(8'hC3, 1'b1, 1'b1, 16'hFFFD, 1'b1);	// end after lead
		add_row(8'hF0, 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(8'h90, 1'b1, 1'b0, 16'h0000, 1'b0);	// end mid continuation
		add_row(8'hF8, 1'b0, 1'b1, 16'hFFFD, 1'b1);
		add_row(8'h00, 1'b1, 1'b0, 16'h0000, 1'b0);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i])
			send_byte(stim_rows[i].beat, stim_rows[i].typed, stim_rows[i].unit);
		drain_units();

		live_items = 0;
		next_drain = 150;
		while (live_items < 420) begin
			plan_sequence();
			while (byte_plan.size() != 0)
				send_byte(byte_plan.pop_front(), 1'b0, '0);
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
			if (live_items >= next_drain) begin
				drain_units();
				next_drain += 150;
			end
		end

		drain_units();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_units.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
